/* rtl/core/rgbhsl_pkg.sv */
// ----------------------------------------------------------------------------
// rgbhsl_pkg
// Shared widths, constants and the hand-off type for the RGB to HSL converter.
// ----------------------------------------------------------------------------
package rgbhsl_pkg;

  // Component and result width.
  localparam int PIX_W = 8;

  // Quotient bits produced by each divider (one bit per pipeline stage).
  localparam int QUO_W = 8;

  // Divisor widths: saturation divides by at most 255, hue by 6*d <= 1530.
  localparam int SAT_DEN_W = 8;
  localparam int HUE_DEN_W = 11;

  // Dividend widths follow from the divisor and quotient widths.
  localparam int SAT_NUM_W = SAT_DEN_W + QUO_W;
  localparam int HUE_NUM_W = HUE_DEN_W + QUO_W;

  // Full-scale component value.
  localparam logic [PIX_W-1:0] PIX_FULL = 8'd255;

  // Twice full scale, the light-half saturation reference.
  localparam logic [PIX_W:0] PIX_TWICE = 9'd510;

  // Packed beat widths.
  localparam int BEAT_W = 3 * PIX_W;

  // Division requests handed from the front end to the divider pipeline.
  typedef struct packed {
    logic                 valid;
    logic                 gray;
    logic [PIX_W-1:0]     light;
    logic [SAT_NUM_W-1:0] sat_num;
    logic [SAT_DEN_W-1:0] sat_den;
    logic [HUE_NUM_W-1:0] hue_num;
    logic [HUE_DEN_W-1:0] hue_den;
  } div_req_t;

endpackage

/* rtl/core/rgbhsl_front.sv */
// ----------------------------------------------------------------------------
// rgbhsl_front
// Two register stages: min/max and sector decode, then dividend and divisor
// preparation for the saturation and hue dividers.
// ----------------------------------------------------------------------------
module rgbhsl_front
  import rgbhsl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             ce,
  input  logic             in_valid,
  input  logic [PIX_W-1:0] red,
  input  logic [PIX_W-1:0] green,
  input  logic [PIX_W-1:0] blue,
  output div_req_t         req
);

  logic [PIX_W-1:0]     mx_nxt;
  logic [PIX_W-1:0]     mn_nxt;
  logic [PIX_W-1:0]     d_nxt;
  logic [PIX_W:0]       sum_nxt;
  logic [HUE_DEN_W-1:0] n_nxt;
  logic                 neg_nxt;

  logic                 s1_v_r;
  logic [PIX_W-1:0]     s1_d_r;
  logic [PIX_W:0]       s1_sum_r;
  logic [HUE_DEN_W-1:0] s1_n_r;
  logic                 s1_neg_r;

  logic [HUE_DEN_W-1:0] six_d;
  logic [HUE_DEN_W-1:0] n_wrap;
  logic [PIX_W:0]       den_light;
  div_req_t             req_nxt;
  div_req_t             req_r;

  // Stage one: extremes, spread, sum and the signed hue offset per sector.
  // The sector test checks red first, then green, then blue.
  always_comb begin
    mx_nxt  = (red > green) ? red : green;
    mx_nxt  = (mx_nxt > blue) ? mx_nxt : blue;
    mn_nxt  = (red < green) ? red : green;
    mn_nxt  = (mn_nxt < blue) ? mn_nxt : blue;
    d_nxt   = mx_nxt - mn_nxt;
    sum_nxt = {1'b0, mx_nxt} + {1'b0, mn_nxt};
    // Only the red sector can give a negative offset; the blue sector reaches
    // 5*d, which does not fit a signed reading of the offset.
    neg_nxt = (red == mx_nxt) && (green < blue);
    if (red == mx_nxt) begin
      n_nxt = {3'b000, green} - {3'b000, blue};
    end else if (green == mx_nxt) begin
      n_nxt = {2'b00, d_nxt, 1'b0} + {3'b000, blue} - {3'b000, red};
    end else begin
      n_nxt = {1'b0, d_nxt, 2'b00} + {3'b000, red} - {3'b000, green};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (ce) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_d_r   <= d_nxt;
      s1_sum_r <= sum_nxt;
      s1_n_r   <= n_nxt;
      s1_neg_r <= neg_nxt;
    end
  end

  // Stage two: wrap a negative hue offset by 6*d and scale both dividends
  // by 255 with a shift and a subtract.
  always_comb begin
    six_d     = {1'b0, s1_d_r, 2'b00} + {2'b00, s1_d_r, 1'b0};
    n_wrap    = s1_neg_r ? (s1_n_r + six_d) : s1_n_r;
    den_light = PIX_TWICE - s1_sum_r;

    req_nxt.valid   = s1_v_r;
    req_nxt.gray    = (s1_d_r == '0);
    req_nxt.light   = s1_sum_r[PIX_W:1];
    req_nxt.sat_num = {s1_d_r, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, s1_d_r};
    req_nxt.sat_den = (s1_sum_r < {1'b0, PIX_FULL}) ? s1_sum_r[PIX_W-1:0]
                                                     : den_light[PIX_W-1:0];
    req_nxt.hue_num = {n_wrap, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, n_wrap};
    req_nxt.hue_den = six_d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r.valid <= 1'b0;
    end else if (ce) begin
      req_r.valid <= req_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      req_r.gray    <= req_nxt.gray;
      req_r.light   <= req_nxt.light;
      req_r.sat_num <= req_nxt.sat_num;
      req_r.sat_den <= req_nxt.sat_den;
      req_r.hue_num <= req_nxt.hue_num;
      req_r.hue_den <= req_nxt.hue_den;
    end
  end

  assign req = req_r;

endmodule

/* rtl/core/rgbhsl_div.sv */
// ----------------------------------------------------------------------------
// rgbhsl_div
// Pipelined restoring divider, one quotient bit per register stage. The
// dividend's upper DEN_W bits must be below the divisor, so the quotient
// fits in QW bits.
// ----------------------------------------------------------------------------
module rgbhsl_div
  import rgbhsl_pkg::*;
#(
  parameter int DEN_W = SAT_DEN_W,
  parameter int QW    = QUO_W
) (
  input  logic                clk,
  input  logic                ce,
  input  logic [DEN_W+QW-1:0] num,
  input  logic [DEN_W-1:0]    den,
  output logic [QW-1:0]       quo
);

  logic [DEN_W-1:0] rem_r [QW];
  logic [DEN_W-1:0] den_r [QW];
  logic [QW-1:0]    lo_r  [QW];
  logic [QW-1:0]    quo_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QW-1:0]    lo_in;
    logic [QW-1:0]    quo_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fit;

    // The first stage loads the dividend; later stages chain on.
    if (k == 0) begin : g_first
      assign rem_in = num[DEN_W+QW-1:QW];
      assign den_in = den;
      assign lo_in  = num[QW-1:0];
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign lo_in  = lo_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    // Bring down the next dividend bit and subtract when it fits.
    assign trial = {rem_in, lo_in[QW-1]};
    assign diff  = trial - {1'b0, den_in};
    assign fit   = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[k] <= fit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        den_r[k] <= den_in;
        lo_r[k]  <= {lo_in[QW-2:0], 1'b0};
        quo_r[k] <= {quo_in[QW-2:0], fit};
      end
    end
  end

  assign quo = quo_r[QW-1];

endmodule

/* rtl/core/rgb_to_hsl_8bit.sv */
// ----------------------------------------------------------------------------
// rgb_to_hsl_8bit
// Streaming 8-bit RGB to 8-bit HSL pixel converter.
// ----------------------------------------------------------------------------
// Path: an accepted beat passes two front-end stages, eight divider stages (one
// quotient bit each) and the output register, which raises out_tvalid; the
// first front-end stage loads at the accepting edge. Throughput: one pixel per cycle
// while in_tready is high; a two-entry output register and skid buffer keep
// in_tready registered and let the input run while a result waits.
// Reset: synchronous active-low rst_n clears all valid bits; data is not reset.
module rgb_to_hsl_8bit
  import rgbhsl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [BEAT_W-1:0] in_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [BEAT_W-1:0] out_tdata   // hue [7:0], saturation [15:8], lightness [23:16]
);

  logic              ce;
  div_req_t          req;
  logic [QUO_W-1:0]  sat_q;
  logic [QUO_W-1:0]  hue_q;

  logic              v_r     [QUO_W];
  logic              gray_r  [QUO_W];
  logic [PIX_W-1:0]  light_r [QUO_W];

  logic              last_v;
  logic [BEAT_W-1:0] last_data;
  logic              take;

  logic              out_v_r;
  logic [BEAT_W-1:0] out_data_r;
  logic              skid_v_r;
  logic [BEAT_W-1:0] skid_data_r;

  // The whole pipeline moves unless the skid buffer is holding a beat.
  assign ce        = !skid_v_r;
  assign in_tready = ce;

  rgbhsl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .ce       (ce),
    .in_valid (in_tvalid),
    .red      (in_tdata[PIX_W-1:0]),
    .green    (in_tdata[2*PIX_W-1:PIX_W]),
    .blue     (in_tdata[3*PIX_W-1:2*PIX_W]),
    .req      (req)
  );

  rgbhsl_div #(
    .DEN_W (SAT_DEN_W),
    .QW    (QUO_W)
  ) u_sat_div (
    .clk (clk),
    .ce  (ce),
    .num (req.sat_num),
    .den (req.sat_den),
    .quo (sat_q)
  );

  rgbhsl_div #(
    .DEN_W (HUE_DEN_W),
    .QW    (QUO_W)
  ) u_hue_div (
    .clk (clk),
    .ce  (ce),
    .num (req.hue_num),
    .den (req.hue_den),
    .quo (hue_q)
  );

  // Valid bits alongside the divider stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QUO_W; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (ce) begin
      v_r[0] <= req.valid;
      for (int k = 1; k < QUO_W; k++) begin
        v_r[k] <= v_r[k-1];
      end
    end
  end

  // Lightness and the gray flag ride along with the divisions.
  always_ff @(posedge clk) begin
    if (ce) begin
      gray_r[0]  <= req.gray;
      light_r[0] <= req.light;
      for (int k = 1; k < QUO_W; k++) begin
        gray_r[k]  <= gray_r[k-1];
        light_r[k] <= light_r[k-1];
      end
    end
  end

  // A gray pixel forces hue and saturation to zero.
  assign last_v    = v_r[QUO_W-1];
  assign last_data = gray_r[QUO_W-1] ? {light_r[QUO_W-1], {(2*PIX_W){1'b0}}}
                                     : {light_r[QUO_W-1], sat_q, hue_q};
  assign take      = out_v_r && out_tready;

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (take) begin
        skid_v_r <= 1'b0;
      end
    end else if (last_v) begin
      if (out_v_r && !take) begin
        skid_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end else if (take) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (take) begin
        out_data_r <= skid_data_r;
      end
    end else if (last_v) begin
      if (out_v_r && !take) begin
        skid_data_r <= last_data;
      end else begin
        out_data_r <= last_data;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  // The skid entry only fills behind an occupied output register.
  a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid buffer holds a beat while the output register is empty");

  // The skid entry fills only when the output was stalled the cycle before.
  a_skid_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_tready))
    else $error("skid buffer filled without an output stall");

  // Hue is one turn scaled to 255 and never reaches a full turn.
  a_hue_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[PIX_W-1:0] != PIX_FULL))
    else $error("hue reached a full turn");

endmodule

/* tb/tb_rgb_to_hsl_8bit.sv */
// ----------------------------------------------------------------------------
// tb_rgb_to_hsl_8bit
// Self-checking stream testbench for the 8-bit RGB to HSL pixel converter.
// A short table of directed pixels (black, white, primaries, grays, hue wrap,
// ties between components, both saturation halves and the boundary between
// them) is followed by several hundred random pixels. Every accepted input
// beat pushes its expected HSL triple, from its row or an exact integer model,
// and every accepted output beat is checked field by field against the oldest
// one. Both sides idle at random, the receiver once holds off long enough to
// back the pipeline up, and the sender twice waits for the pipeline to drain.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsl_8bit
  import rgbhsl_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned IDLE_PCT    = 37;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic [PIX_W-1:0] hue;
    logic [PIX_W-1:0] saturation;
    logic [PIX_W-1:0] lightness;
  } hsl_t;

  // One directed row: a pixel and, where it is obvious, its result.
  typedef struct packed {
    pix_t px;
    logic typed;
    hsl_t hsl;
  } pix_row_t;

  // An expected result together with the pixel that caused it.
  typedef struct packed {
    pix_t px;
    hsl_t hsl;
  } hsl_entry_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [BEAT_W-1:0] in_tdata   = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [BEAT_W-1:0] out_tdata;

  hsl_entry_t  pending_hsl[$];
  int unsigned err_cnt       = 0;
  int unsigned cycle_cnt     = 0;
  bit          tx_gaps_on    = 1'b1;
  bit          rx_stalls_on  = 1'b1;
  int unsigned hold_off_len  = 0;

  // Directed pixels; rows with typed set carry their result.
  pix_row_t dir_rows [25] = '{
    '{'{8'd0,   8'd0,   8'd0},   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{'{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd0,   8'd0,   8'd255}},
    '{'{8'd255, 8'd0,   8'd0},   1'b1, '{8'd0,   8'd255, 8'd127}},
    '{'{8'd0,   8'd255, 8'd0},   1'b1, '{8'd85,  8'd255, 8'd127}},
    '{'{8'd0,   8'd0,   8'd255}, 1'b1, '{8'd170, 8'd255, 8'd127}},
    '{'{8'd128, 8'd128, 8'd128}, 1'b1, '{8'd0,   8'd0,   8'd128}},
    '{'{8'd1,   8'd1,   8'd1},   1'b1, '{8'd0,   8'd0,   8'd1}},
    '{'{8'd255, 8'd255, 8'd0},   1'b0, '0},
    '{'{8'd0,   8'd255, 8'd255}, 1'b0, '0},
    '{'{8'd255, 8'd0,   8'd255}, 1'b0, '0},
    '{'{8'd255, 8'd0,   8'd1},   1'b0, '0},
    '{'{8'd1,   8'd0,   8'd0},   1'b0, '0},
    '{'{8'd254, 8'd255, 8'd254}, 1'b0, '0},
    '{'{8'd127, 8'd128, 8'd127}, 1'b0, '0},
    '{'{8'd127, 8'd127, 8'd128}, 1'b0, '0},
    '{'{8'd126, 8'd128, 8'd127}, 1'b0, '0},
    '{'{8'd0,   8'd1,   8'd0},   1'b0, '0},
    '{'{8'd0,   8'd0,   8'd1},   1'b0, '0},
    '{'{8'd200, 8'd50,  8'd100}, 1'b0, '0},
    '{'{8'd30,  8'd200, 8'd100}, 1'b0, '0},
    '{'{8'd90,  8'd10,  8'd240}, 1'b0, '0},
    '{'{8'd10,  8'd90,  8'd240}, 1'b0, '0},
    '{'{8'd255, 8'd254, 8'd0},   1'b0, '0},
    '{'{8'd0,   8'd255, 8'd254}, 1'b0, '0},
    '{'{8'd170, 8'd85,  8'd255}, 1'b0, '0}
  };

  rgb_to_hsl_8bit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Exact integer conversion of one pixel; every quotient is non-negative.
  function automatic hsl_t predict_hsl(input pix_t px);
    logic [PIX_W-1:0] mx;
    logic [PIX_W-1:0] mn;
    logic [PIX_W:0]   sum;
    int               d;
    int               den;
    int               n;
    int               six_d;
    hsl_t             res;
    mx  = (px.red > px.green) ? px.red : px.green;
    mx  = (mx > px.blue) ? mx : px.blue;
    mn  = (px.red < px.green) ? px.red : px.green;
    mn  = (mn < px.blue) ? mn : px.blue;
    d   = int'(mx) - int'(mn);
    sum = {1'b0, mx} + {1'b0, mn};
    res.lightness  = sum[PIX_W:1];
    res.hue        = '0;
    res.saturation = '0;
    if (d != 0) begin
      // Dark half divides by the sum, light half by its distance from 510.
      den = (sum < 9'd255) ? int'(sum) : 510 - int'(sum);
      res.saturation = PIX_W'((255 * d) / den);
      // Red wins ties, then green, then blue.
      six_d = 6 * d;
      if (px.red == mx) begin
        n = int'(px.green) - int'(px.blue);
      end else if (px.green == mx) begin
        n = 2 * d + int'(px.blue) - int'(px.red);
      end else begin
        n = 4 * d + int'(px.red) - int'(px.green);
      end
      if (n < 0) begin
        n = n + six_d;
      end
      res.hue = PIX_W'((255 * n) / six_d);
    end
    return res;
  endfunction

  // Random pixel drawn from a mix of shapes that reach the corner cases.
  function automatic pix_t random_pixel();
    int   comp [3];
    int   corner [6] = '{0, 1, 127, 128, 254, 255};
    int   lo;
    int   hi;
    int   j;
    int   tmp;
    pix_t px;
    case ($urandom_range(0, 9))
      5: begin
        // Gray pixel.
        comp[0] = $urandom_range(0, 255);
        comp[1] = comp[0];
        comp[2] = comp[0];
      end
      6: begin
        // Two equal components, which exercises the sector tie rule.
        comp[0] = $urandom_range(0, 255);
        comp[1] = comp[0];
        comp[2] = $urandom_range(0, 255);
      end
      7: begin
        comp[0] = corner[$urandom_range(0, 5)];
        comp[1] = corner[$urandom_range(0, 5)];
        comp[2] = corner[$urandom_range(0, 5)];
      end
      8: begin
        // Max plus min close to the saturation boundary at 255.
        lo = $urandom_range(0, 127);
        hi = 255 - lo + int'($urandom_range(0, 2)) - 1;
        if (hi > 255) begin
          hi = 255;
        end
        comp[0] = lo;
        comp[1] = hi;
        comp[2] = $urandom_range(lo, hi);
      end
      9: begin
        // Nearly gray: spread of at most two.
        lo = $urandom_range(0, 253);
        comp[0] = lo + int'($urandom_range(0, 2));
        comp[1] = lo + int'($urandom_range(0, 2));
        comp[2] = lo + int'($urandom_range(0, 2));
      end
      default: begin
        comp[0] = $urandom_range(0, 255);
        comp[1] = $urandom_range(0, 255);
        comp[2] = $urandom_range(0, 255);
      end
    endcase
    // Shuffle so that any component can take any role.
    for (int i = 2; i > 0; i--) begin
      j       = $urandom_range(0, i);
      tmp     = comp[i];
      comp[i] = comp[j];
      comp[j] = tmp;
    end
    px.red   = PIX_W'(comp[0]);
    px.green = PIX_W'(comp[1]);
    px.blue  = PIX_W'(comp[2]);
    return px;
  endfunction

  // Offers one pixel, waits for the handshake and records its result.
  task automatic send_pixel(input pix_t px, input logic typed, input hsl_t typed_hsl);
    hsl_entry_t entry;
    while (tx_gaps_on && ($urandom_range(0, 99) < IDLE_PCT)) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {px.blue, px.green, px.red};
    do begin
      @(posedge clk);
    end while (!in_tready);
    entry.px  = px;
    entry.hsl = typed ? typed_hsl : predict_hsl(px);
    pending_hsl.push_back(entry);
  endtask

  task automatic send_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_pixel(random_pixel(), 1'b0, '0);
    end
  endtask

  task automatic report_mismatch(input string what, input pix_t px,
                                 input int got_v, input int want_v);
    $display("%0t ns: %s for rgb (%0d,%0d,%0d): got %0d, expected %0d",
             $realtime, what, px.red, px.green, px.blue, got_v, want_v);
    err_cnt++;
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_len != 0) begin
        out_tready <= 1'b0;
        for (int unsigned k = 1; k < hold_off_len; k++) begin
          @(posedge clk);
        end
        hold_off_len = 0;
      end else if (rx_stalls_on) begin
        out_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Output beat checker.
  always @(posedge clk) begin : result_check
    hsl_t       got;
    hsl_entry_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.hue        = out_tdata[PIX_W-1:0];
      got.saturation = out_tdata[2*PIX_W-1:PIX_W];
      got.lightness  = out_tdata[3*PIX_W-1:2*PIX_W];
      if (pending_hsl.size() == 0) begin
        report_mismatch("result beat with nothing pending", '0, int'(out_tdata), 0);
      end else begin
        want = pending_hsl.pop_front();
        if (got.hue != want.hsl.hue) begin
          report_mismatch("hue", want.px, got.hue, want.hsl.hue);
        end
        if (got.saturation != want.hsl.saturation) begin
          report_mismatch("saturation", want.px, got.saturation, want.hsl.saturation);
        end
        if (got.lightness != want.hsl.lightness) begin
          report_mismatch("lightness", want.px, got.lightness, want.hsl.lightness);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_rgb_to_hsl_8bit: errors");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pixels with random idling on both sides.
    foreach (dir_rows[i]) begin
      send_pixel(dir_rows[i].px, dir_rows[i].typed, dir_rows[i].hsl);
    end

    send_random(250);

    // Long receiver hold-off while the sender keeps offering beats.
    tx_gaps_on   = 1'b0;
    hold_off_len = 240;
    send_random(80);

    // Sender pauses until the pipeline has drained.
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_hsl.size() != 0) begin
      @(posedge clk);
    end

    // Long stretch at full rate with no idling on either side.
    rx_stalls_on = 1'b0;
    send_random(250);

    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    send_random(320);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_hsl.size() != 0) begin
      @(posedge clk);
    end
    repeat (24) @(posedge clk);

    if (err_cnt == 0) begin
      $display("tb_rgb_to_hsl_8bit: clean");
    end else begin
      $display("tb_rgb_to_hsl_8bit: errors");
    end
    $finish;
  end

endmodule
